// ===== sv/hcim_pkg.sv =====
// Types, constants and codes shared by the halo cell index map.
`default_nettype none
package hcim_pkg;
	localparam int MAX_CELLS_PER_AXIS = 64;
	localparam int N_W = 7;
	localparam int C_W = 8;
	localparam int NUM_W = 19;
	localparam int W_W = 8;
	localparam int P_W = 16;
	localparam int S_W = 22;
	localparam int REM_W = 14;
	localparam int FRONT_STAGES = 7;
	localparam int LATENCY = FRONT_STAGES + NUM_W + REM_W + 1;

	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	localparam logic [1:0] CFG_CELLS_X = 2'd0;
	localparam logic [1:0] CFG_CELLS_Y = 2'd1;
	localparam logic [1:0] CFG_CELLS_Z = 2'd2;

	localparam logic [2:0] RG_INT = 3'd0;
	localparam logic [2:0] RG_XLO = 3'd1;
	localparam logic [2:0] RG_XHI = 3'd2;
	localparam logic [2:0] RG_YLO = 3'd3;
	localparam logic [2:0] RG_YHI = 3'd4;
	localparam logic [2:0] RG_ZLO = 3'd5;
	localparam logic [2:0] RG_ZHI = 3'd6;

	typedef struct packed {
		logic opcode;
		logic signed [C_W-1:0] pos_x;
		logic signed [C_W-1:0] pos_y;
		logic signed [C_W-1:0] pos_z;
		logic [NUM_W-1:0] cell_number;
	} hcim_cmd_t;

	typedef struct packed {
		logic [NUM_W-1:0] out_number;
		logic signed [C_W-1:0] out_x;
		logic signed [C_W-1:0] out_y;
		logic signed [C_W-1:0] out_z;
		logic range_error;
	} hcim_rsp_t;

	typedef struct packed {
		logic op;
		logic err;
		logic [2:0] region;
		logic [NUM_W-1:0] number;
		logic [N_W-1:0] nx;
		logic [N_W-1:0] ny;
		logic [N_W-1:0] nz;
	} hcim_tag_t;

	typedef struct packed {
		hcim_tag_t tag;
		logic [C_W-1:0] qa;
		logic [C_W-1:0] ra;
	} hcim_tagb_t;
endpackage
`default_nettype wire

// ===== sv/hcim_div_cell.sv =====
// One restoring division step: a cell of the divider chain.
`default_nettype none
module hcim_div_cell #(
	parameter int NW = 19,
	parameter int DW = 14,
	parameter int PW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          prev_vld,
	input  wire logic [DW-1:0] prev_rem,
	input  wire logic [NW-1:0] prev_dq,
	input  wire logic [DW-1:0] prev_dvs,
	input  wire logic [PW-1:0] prev_tag,
	output logic               next_vld,
	output logic [DW-1:0]      next_rem,
	output logic [NW-1:0]      next_dq,
	output logic [DW-1:0]      next_dvs,
	output logic [PW-1:0]      next_tag
);
	logic [DW:0] trial;
	logic [DW:0] diff;
	logic        ge;

	assign trial = {prev_rem, prev_dq[NW-1]};
	assign diff  = trial - {1'b0, prev_dvs};
	assign ge    = trial >= {1'b0, prev_dvs};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_vld <= 1'b0;
		end else begin
			next_vld <= prev_vld;
		end
	end

	always_ff @(posedge clk) begin
		next_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
		next_dq  <= {prev_dq[NW-2:0], ge};
		next_dvs <= prev_dvs;
		next_tag <= prev_tag;
	end
endmodule
`default_nettype wire

// ===== sv/hcim_front.sv =====
// Front pipeline: grid sizes, encode sum, decode region and face split.
`default_nettype none
module hcim_front
	import hcim_pkg::*;
#(
	parameter int MaxCells = MAX_CELLS_PER_AXIS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire hcim_cmd_t        cmd,
	input  wire logic [N_W-1:0]   cells_x,
	input  wire logic [N_W-1:0]   cells_y,
	input  wire logic [N_W-1:0]   cells_z,
	output logic                  vld,
	output logic [NUM_W-1:0]      dividend,
	output logic [REM_W-1:0]      divisor,
	output hcim_tag_t             tag
);
	function automatic logic [N_W-1:0] eff(input logic [N_W-1:0] r);
		logic [N_W-1:0] v;
		v = r;
		if (r == '0)
			v = N_W'(1);
		else if (int'(r) > MaxCells)
			v = N_W'(MaxCells);
		return v;
	endfunction

	// s1
	logic vld_s1, op_s1;
	logic signed [C_W-1:0] x_s1, y_s1, z_s1;
	logic [NUM_W-1:0] num_s1;
	logic [N_W-1:0] nx_s1, ny_s1, nz_s1;
	logic [W_W-1:0] w_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		op_s1  <= cmd.opcode;
		x_s1   <= cmd.pos_x;
		y_s1   <= cmd.pos_y;
		z_s1   <= cmd.pos_z;
		num_s1 <= cmd.cell_number;
		nx_s1  <= eff(cells_x);
		ny_s1  <= eff(cells_y);
		nz_s1  <= eff(cells_z);
		w_s1   <= {1'b0, eff(cells_x)} + W_W'(2);
	end

	// s2
	logic signed [C_W:0] xs, ys, zs, nxs, nys, nzs;
	logic bad;
	logic [2:0] rg;
	logic [C_W-1:0] xp1, yp1, ma, mb, tail;

	assign xs  = $signed({x_s1[C_W-1], x_s1});
	assign ys  = $signed({y_s1[C_W-1], y_s1});
	assign zs  = $signed({z_s1[C_W-1], z_s1});
	assign nxs = $signed({2'b00, nx_s1});
	assign nys = $signed({2'b00, ny_s1});
	assign nzs = $signed({2'b00, nz_s1});
	assign bad = xs < -9'sd1 || xs > nxs || ys < -9'sd1 || ys > nys ||
		zs < -9'sd1 || zs > nzs;
	assign xp1 = x_s1 + C_W'(1);
	assign yp1 = y_s1 + C_W'(1);

	always_comb begin
		if (zs == nzs)
			rg = RG_ZHI;
		else if (zs == -9'sd1)
			rg = RG_ZLO;
		else if (ys == nys)
			rg = RG_YHI;
		else if (ys == -9'sd1)
			rg = RG_YLO;
		else if (xs == nxs)
			rg = RG_XHI;
		else if (xs == -9'sd1)
			rg = RG_XLO;
		else
			rg = RG_INT;
	end

	always_comb begin
		case (rg)
			RG_ZHI, RG_ZLO: begin
				ma = w_s1;
				mb = yp1;
				tail = xp1;
			end
			RG_YHI, RG_YLO: begin
				ma = w_s1;
				mb = {1'b0, z_s1[N_W-1:0]};
				tail = xp1;
			end
			RG_XHI, RG_XLO: begin
				ma = {1'b0, ny_s1};
				mb = {1'b0, z_s1[N_W-1:0]};
				tail = {1'b0, y_s1[N_W-1:0]};
			end
			default: begin
				ma = {1'b0, nx_s1};
				mb = {1'b0, y_s1[N_W-1:0]};
				tail = {1'b0, x_s1[N_W-1:0]};
			end
		endcase
	end

	logic vld_s2, op_s2, bad_s2;
	logic [2:0] rg_s2;
	logic [C_W-1:0] small_s2;
	logic [NUM_W-1:0] num_s2;
	logic [N_W-1:0] nx_s2, ny_s2, nz_s2, z_s2;
	logic [W_W-1:0] w_s2;
	logic [P_W-1:0] ta_s2, nxny_s2, nynz_s2, nzw_s2, wy2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s2    <= op_s1;
		bad_s2   <= bad;
		rg_s2    <= rg;
		small_s2 <= tail;
		num_s2   <= num_s1;
		nx_s2    <= nx_s1;
		ny_s2    <= ny_s1;
		nz_s2    <= nz_s1;
		z_s2     <= z_s1[N_W-1:0];
		w_s2     <= w_s1;
		ta_s2    <= P_W'(ma) * P_W'(mb);
		nxny_s2  <= P_W'(nx_s1) * P_W'(ny_s1);
		nynz_s2  <= P_W'(ny_s1) * P_W'(nz_s1);
		nzw_s2   <= P_W'(nz_s1) * P_W'(w_s1);
		wy2_s2   <= P_W'(w_s1) * (P_W'(ny_s1) + P_W'(2));
	end

	// s3
	logic vld_s3, op_s3, bad_s3;
	logic [2:0] rg_s3;
	logic [C_W-1:0] small_s3;
	logic [NUM_W-1:0] num_s3;
	logic [N_W-1:0] nx_s3, ny_s3, nz_s3;
	logic [W_W-1:0] w_s3;
	logic [P_W-1:0] ta_s3, nxny_s3, nynz_s3, nzw_s3, wy2_s3;
	logic [S_W-1:0] int_s3, pz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		op_s3    <= op_s2;
		bad_s3   <= bad_s2;
		rg_s3    <= rg_s2;
		small_s3 <= small_s2;
		num_s3   <= num_s2;
		nx_s3    <= nx_s2;
		ny_s3    <= ny_s2;
		nz_s3    <= nz_s2;
		w_s3     <= w_s2;
		ta_s3    <= ta_s2;
		nxny_s3  <= nxny_s2;
		nynz_s3  <= nynz_s2;
		nzw_s3   <= nzw_s2;
		wy2_s3   <= wy2_s2;
		int_s3   <= S_W'(nxny_s2) * S_W'(nz_s2);
		pz_s3    <= S_W'(nxny_s2) * S_W'(z_s2);
	end

	// s4
	logic vld_s4, op_s4, bad_s4;
	logic [2:0] rg_s4;
	logic [C_W-1:0] small_s4;
	logic [NUM_W-1:0] num_s4;
	logic [N_W-1:0] nx_s4, ny_s4, nz_s4;
	logic [W_W-1:0] w_s4;
	logic [P_W-1:0] ta_s4, nxny_s4, nynz_s4, nzw_s4, wy2_s4;
	logic [S_W-1:0] int_s4, pz_s4, by_s4, bz_s4, bxh_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		op_s4    <= op_s3;
		bad_s4   <= bad_s3;
		rg_s4    <= rg_s3;
		small_s4 <= small_s3;
		num_s4   <= num_s3;
		nx_s4    <= nx_s3;
		ny_s4    <= ny_s3;
		nz_s4    <= nz_s3;
		w_s4     <= w_s3;
		ta_s4    <= ta_s3;
		nxny_s4  <= nxny_s3;
		nynz_s4  <= nynz_s3;
		nzw_s4   <= nzw_s3;
		wy2_s4   <= wy2_s3;
		int_s4   <= int_s3;
		pz_s4    <= pz_s3;
		by_s4    <= int_s3 + (S_W'(nynz_s3) << 1);
		bz_s4    <= int_s3 + (S_W'(nynz_s3) << 1) + (S_W'(nzw_s3) << 1);
		bxh_s4   <= int_s3 + S_W'(nynz_s3);
	end

	// s5
	logic [S_W-1:0] bsel;

	always_comb begin
		case (rg_s4)
			RG_ZHI: bsel = bz_s4 + S_W'(wy2_s4);
			RG_ZLO: bsel = bz_s4;
			RG_YHI: bsel = by_s4 + S_W'(nzw_s4);
			RG_YLO: bsel = by_s4;
			RG_XHI: bsel = bxh_s4;
			RG_XLO: bsel = int_s4;
			default: bsel = pz_s4;
		endcase
	end

	logic vld_s5, op_s5, bad_s5, ltint_s5, ltby_s5, ltbz_s5;
	logic [C_W-1:0] small_s5;
	logic [NUM_W-1:0] num_s5;
	logic [N_W-1:0] nx_s5, ny_s5, nz_s5;
	logic [W_W-1:0] w_s5;
	logic [P_W-1:0] ta_s5, nxny_s5, nynz_s5, nzw_s5, wy2_s5;
	logic [S_W-1:0] bsel_s5, tot_s5, rx_s5, ry_s5, rz_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		op_s5    <= op_s4;
		bad_s5   <= bad_s4;
		small_s5 <= small_s4;
		num_s5   <= num_s4;
		nx_s5    <= nx_s4;
		ny_s5    <= ny_s4;
		nz_s5    <= nz_s4;
		w_s5     <= w_s4;
		ta_s5    <= ta_s4;
		nxny_s5  <= nxny_s4;
		nynz_s5  <= nynz_s4;
		nzw_s5   <= nzw_s4;
		wy2_s5   <= wy2_s4;
		bsel_s5  <= bsel;
		tot_s5   <= bz_s4 + (S_W'(wy2_s4) << 1);
		rx_s5    <= S_W'(num_s4) - int_s4;
		ry_s5    <= S_W'(num_s4) - by_s4;
		rz_s5    <= S_W'(num_s4) - bz_s4;
		ltint_s5 <= S_W'(num_s4) < int_s4;
		ltby_s5  <= S_W'(num_s4) < by_s4;
		ltbz_s5  <= S_W'(num_s4) < bz_s4;
	end

	// s6
	logic [2:0] drg;
	logic [S_W-1:0] dr;
	logic [P_W-1:0] face;
	logic [REM_W-1:0] dvs;

	always_comb begin
		if (ltint_s5) begin
			drg = RG_INT;
			dr = S_W'(num_s5);
			face = nynz_s5;
			dvs = nxny_s5[REM_W-1:0];
		end else if (ltby_s5) begin
			drg = RG_XLO;
			dr = rx_s5;
			face = nynz_s5;
			dvs = REM_W'(ny_s5);
		end else if (ltbz_s5) begin
			drg = RG_YLO;
			dr = ry_s5;
			face = nzw_s5;
			dvs = REM_W'(w_s5);
		end else begin
			drg = RG_ZLO;
			dr = rz_s5;
			face = wy2_s5;
			dvs = REM_W'(w_s5);
		end
	end

	logic vld_s6, op_s6, err_s6;
	logic [2:0] rg_s6;
	logic [NUM_W-1:0] number_s6, r_s6;
	logic [N_W-1:0] nx_s6, ny_s6, nz_s6;
	logic [P_W-1:0] face_s6;
	logic [REM_W-1:0] dvs_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		op_s6     <= op_s5;
		err_s6    <= (op_s5 == OP_DECODE) ? (S_W'(num_s5) >= tot_s5) : bad_s5;
		rg_s6     <= drg;
		number_s6 <= NUM_W'(bsel_s5 + S_W'(ta_s5) + S_W'(small_s5));
		r_s6      <= dr[NUM_W-1:0];
		nx_s6     <= nx_s5;
		ny_s6     <= ny_s5;
		nz_s6     <= nz_s5;
		face_s6   <= face;
		dvs_s6    <= dvs;
	end

	// s7
	logic hi;
	logic [2:0] rg7;

	assign hi = (rg_s6 != RG_INT) && (r_s6 >= NUM_W'(face_s6));

	always_comb begin
		case (rg_s6)
			RG_XLO: rg7 = hi ? RG_XHI : RG_XLO;
			RG_YLO: rg7 = hi ? RG_YHI : RG_YLO;
			RG_ZLO: rg7 = hi ? RG_ZHI : RG_ZLO;
			default: rg7 = RG_INT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= 1'b0;
		end else begin
			vld <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		dividend   <= hi ? r_s6 - NUM_W'(face_s6) : r_s6;
		divisor    <= dvs_s6;
		tag.op     <= op_s6;
		tag.err    <= err_s6;
		tag.region <= rg7;
		tag.number <= number_s6;
		tag.nx     <= nx_s6;
		tag.ny     <= ny_s6;
		tag.nz     <= nz_s6;
	end
endmodule
`default_nettype wire

// ===== sv/halo_cell_index_map_core.sv =====
// Top level: configuration registers, front pipeline and two divider cell chains.
// Maps halo-grid cell coordinates to a linear cell number (opcode 0) and back
// (opcode 1). busy stays low: a command is taken in every cycle that start is
// high, and its result appears on rsp with done high after the 7 front
// stages, a 19-cell divider chain, a 14-cell divider chain and the output
// register, in command order. The receiver cannot stall, so done is a
// one-cycle strobe. A write to cells_x/y/z applies to commands started after it.
`default_nettype none
module halo_cell_index_map_core
	import hcim_pkg::*;
#(
	parameter int MaxCellsPerAxis = MAX_CELLS_PER_AXIS
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire hcim_cmd_t      cmd,
	output logic                done,
	output hcim_rsp_t           rsp,
	input  wire logic           cfg_we,
	input  wire logic [1:0]     cfg_idx,
	input  wire logic [N_W-1:0] cfg_data
);
	localparam int TW  = $bits(hcim_tag_t);
	localparam int TBW = $bits(hcim_tagb_t);

	logic [N_W-1:0] cells_x_q, cells_y_q, cells_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_x_q <= N_W'(4);
			cells_y_q <= N_W'(4);
			cells_z_q <= N_W'(4);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_CELLS_X: cells_x_q <= cfg_data;
				CFG_CELLS_Y: cells_y_q <= cfg_data;
				CFG_CELLS_Z: cells_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic a_vld [0:NUM_W];
	logic [REM_W-1:0] a_rem [0:NUM_W];
	logic [NUM_W-1:0] a_dq [0:NUM_W];
	logic [REM_W-1:0] a_dvs [0:NUM_W];
	logic [TW-1:0] a_tag [0:NUM_W];
	hcim_tag_t front_tag;

	hcim_front #(.MaxCells(MaxCellsPerAxis)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start & ~busy), .cmd(cmd),
		.cells_x(cells_x_q), .cells_y(cells_y_q), .cells_z(cells_z_q),
		.vld(a_vld[0]), .dividend(a_dq[0]), .divisor(a_dvs[0]), .tag(front_tag)
	);

	assign a_rem[0] = '0;
	assign a_tag[0] = front_tag;

	for (genvar i = 0; i < NUM_W; i++) begin : g_chain_a
		hcim_div_cell #(.NW(NUM_W), .DW(REM_W), .PW(TW)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.prev_vld(a_vld[i]), .prev_rem(a_rem[i]), .prev_dq(a_dq[i]),
			.prev_dvs(a_dvs[i]), .prev_tag(a_tag[i]),
			.next_vld(a_vld[i+1]), .next_rem(a_rem[i+1]), .next_dq(a_dq[i+1]),
			.next_dvs(a_dvs[i+1]), .next_tag(a_tag[i+1])
		);
	end

	logic b_vld [0:REM_W];
	logic [N_W-1:0] b_rem [0:REM_W];
	logic [REM_W-1:0] b_dq [0:REM_W];
	logic [N_W-1:0] b_dvs [0:REM_W];
	logic [TBW-1:0] b_tag [0:REM_W];
	hcim_tag_t a_end;
	hcim_tagb_t b_start, b_end;

	assign a_end       = a_tag[NUM_W];
	assign b_start.tag = a_end;
	assign b_start.qa  = a_dq[NUM_W][C_W-1:0];
	assign b_start.ra  = a_rem[NUM_W][C_W-1:0];
	assign b_vld[0]    = a_vld[NUM_W];
	assign b_rem[0]    = '0;
	assign b_dq[0]     = a_rem[NUM_W];
	assign b_dvs[0]    = a_end.nx;
	assign b_tag[0]    = b_start;

	for (genvar j = 0; j < REM_W; j++) begin : g_chain_b
		hcim_div_cell #(.NW(REM_W), .DW(N_W), .PW(TBW)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.prev_vld(b_vld[j]), .prev_rem(b_rem[j]), .prev_dq(b_dq[j]),
			.prev_dvs(b_dvs[j]), .prev_tag(b_tag[j]),
			.next_vld(b_vld[j+1]), .next_rem(b_rem[j+1]), .next_dq(b_dq[j+1]),
			.next_dvs(b_dvs[j+1]), .next_tag(b_tag[j+1])
		);
	end

	assign b_end = b_tag[REM_W];

	logic [C_W-1:0] ox, oy, oz, qb, rb;

	assign qb = b_dq[REM_W][C_W-1:0];
	assign rb = {1'b0, b_rem[REM_W]};

	always_comb begin
		case (b_end.tag.region)
			RG_XLO, RG_XHI: begin
				ox = (b_end.tag.region == RG_XLO) ? '1 : {1'b0, b_end.tag.nx};
				oy = b_end.ra;
				oz = b_end.qa;
			end
			RG_YLO, RG_YHI: begin
				ox = b_end.ra - C_W'(1);
				oy = (b_end.tag.region == RG_YLO) ? '1 : {1'b0, b_end.tag.ny};
				oz = b_end.qa;
			end
			RG_ZLO, RG_ZHI: begin
				ox = b_end.ra - C_W'(1);
				oy = b_end.qa - C_W'(1);
				oz = (b_end.tag.region == RG_ZLO) ? '1 : {1'b0, b_end.tag.nz};
			end
			default: begin
				ox = rb;
				oy = qb;
				oz = b_end.qa;
			end
		endcase
	end

	logic dec_ok;
	assign dec_ok = (b_end.tag.op == OP_DECODE) && !b_end.tag.err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= b_vld[REM_W];
		end
	end

	always_ff @(posedge clk) begin
		rsp.range_error <= b_end.tag.err;
		rsp.out_number  <= (b_end.tag.op == OP_ENCODE && !b_end.tag.err) ?
			b_end.tag.number : '0;
		rsp.out_x <= dec_ok ? ox : '0;
		rsp.out_y <= dec_ok ? oy : '0;
		rsp.out_z <= dec_ok ? oz : '0;
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("command transfer lost in pipeline");

	a_err_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.range_error |-> rsp.out_number == '0 && rsp.out_x == '0 &&
			rsp.out_y == '0 && rsp.out_z == '0)
		else $error("range error result carries data");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.out_number != '0 |-> rsp.out_x == '0 && rsp.out_y == '0 &&
			rsp.out_z == '0)
		else $error("result mixes number and coordinates");
endmodule
`default_nettype wire
